// File: rtl/wavp16_pkg.sv
// shared types and constants for the wav pcm16 stream parser
package wavp16_pkg;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_HEAD,
    PH_CHDR,
    PH_FMT,
    PH_SKIP,
    PH_DATA,
    PH_DONE
  } phase_t;

  typedef logic [3:0] status_t;

  localparam status_t ST_SAMPLE       = 4'd0;
  localparam status_t ST_EMPTY_DATA   = 4'd1;
  localparam status_t ST_NOT_WAVE     = 4'd2;
  localparam status_t ST_SIZE_MISMATCH = 4'd3;
  localparam status_t ST_OVERRUN      = 4'd4;
  localparam status_t ST_BAD_FMT      = 4'd5;
  localparam status_t ST_BAD_SAMPLE   = 4'd6;
  localparam status_t ST_BAD_RATE     = 4'd7;
  localparam status_t ST_BAD_CHANNELS = 4'd8;
  localparam status_t ST_INCONSISTENT = 4'd9;
  localparam status_t ST_NO_FMT       = 4'd10;
  localparam status_t ST_MISALIGNED   = 4'd11;
  localparam status_t ST_NO_DATA      = 4'd12;

  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6d66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;

  localparam logic [31:0] FMT_CHUNK_SIZE = 32'd16;
  localparam logic [31:0] CHDR_BYTES     = 32'd8;
  localparam logic [31:0] MIN_FILE_LEN   = 32'd12;
  localparam logic [15:0] FMT_PCM        = 16'd1;
  localparam logic [15:0] PCM_BITS       = 16'd16;

endpackage

// File: rtl/wav_pcm16_stream_parser.sv
// wav pcm16 stream parser: header and chunk walk, fmt checks, sample output
//
// The input channel carries one file byte per word (in_data_byte), with
// in_file_start marking byte 0 of a new file; cfg_wr_en/cfg_wr_data load the
// file length, to be written while the parser is idle; the parser does not
// enforce this. The result channel carries one sample per pair of data-chunk
// bytes with its channel index and the held format, or a single status word
// with out_last set for the first error, an empty data chunk or a missing
// data chunk. The final sample of a file also has out_last set; later bytes
// are dropped until the next file start. Each input word is decoded in the
// cycle it is accepted and its result is registered in the output register;
// one byte per cycle is sustained while the receiver does not stall. A new
// byte is taken while the output register is empty or being drained; when
// the receiver stalls with a result held, in_stall rises and everything
// holds. Reset returns the parser to waiting for a file start with no held
// format and an empty output register; the file length resets to zero.
module wav_pcm16_stream_parser #(
  parameter int MAX_CHANNELS = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [31:0]        cfg_wr_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_data_byte,
  input  logic               in_file_start,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_sample,
  output logic [2:0]         out_channel_index,
  output logic [3:0]         out_channel_count,
  output logic [23:0]        out_sample_rate,
  output wavp16_pkg::status_t out_status,
  output logic               out_last
);
  import wavp16_pkg::*;

  logic [31:0] len_r;
  phase_t      phase_r, phase_nxt;
  logic [31:0] pos_r, pos_nxt;
  logic [31:0] ws_r, ws_nxt;
  logic [31:0] tag_r, tag_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [3:0]  chans_r, chans_nxt;
  logic [23:0] rate_r, rate_nxt;
  logic [7:0]  low_r, low_nxt;
  logic [2:0]  cnt_r, cnt_nxt;
  logic [7:0]  fmt_r [16];

  logic        in_acc, short_err, proc;
  phase_t      c_phase;
  logic [31:0] c_pos, c_ws, c_tag, c_rem;
  logic [3:0]  c_ch;
  logic [23:0] c_rate;
  logic [7:0]  c_low;
  logic [2:0]  c_cnt;
  logic [31:0] next_pos, ws_n, rem_d;
  logic        walk_ok, hdr_sz_bad, overrun;
  logic [32:0] len_m8;

  logic [7:0]  fmt_v [16];
  logic [15:0] f_format, f_nch, f_block, f_bits;
  logic [31:0] f_rate, f_bps;
  logic [27:0] prod;
  logic        nch_bad, rate_bad, block_ok, bps_ok, fmt_ok;
  logic [3:0]  fmt_idx;

  logic        err_v;
  status_t     err_code;
  logic        res_v;
  logic [15:0] res_sample;
  logic [2:0]  res_ch;
  status_t     res_status;
  logic        res_last;

  logic        out_valid_r;
  logic [15:0] out_sample_r;
  logic [2:0]  out_ch_r;
  logic [3:0]  out_count_r;
  logic [23:0] out_rate_r;
  status_t     out_status_r;
  logic        out_last_r;

  assign in_stall  = out_valid_r & out_stall;
  assign in_acc    = in_valid & ~in_stall;
  assign short_err = in_file_start && (len_r < MIN_FILE_LEN);

  // state as seen by this byte, with a file start clearing it first
  assign c_phase = in_file_start ? PH_HEAD : phase_r;
  assign c_pos   = in_file_start ? '0 : pos_r;
  assign c_ws    = in_file_start ? '0 : ws_r;
  assign c_tag   = in_file_start ? '0 : tag_r;
  assign c_rem   = in_file_start ? '0 : rem_r;
  assign c_ch    = in_file_start ? '0 : chans_r;
  assign c_rate  = in_file_start ? '0 : rate_r;
  assign c_low   = in_file_start ? '0 : low_r;
  assign c_cnt   = in_file_start ? '0 : cnt_r;

  assign proc = in_acc && !short_err && (c_phase != PH_IDLE) && (c_phase != PH_DONE);

  assign next_pos   = c_pos + 32'd1;
  assign ws_n       = {in_data_byte, c_ws[31:8]};
  assign rem_d      = c_rem - 32'd1;
  assign walk_ok    = ({1'b0, next_pos} + {1'b0, CHDR_BYTES}) < {1'b0, len_r};
  assign len_m8     = {1'b0, len_r} - {1'b0, CHDR_BYTES};
  assign hdr_sz_bad = {1'b0, ws_n} != len_m8;
  assign overrun    = ({1'b0, next_pos} + {1'b0, ws_n}) > {1'b0, len_r};

  always_comb begin
    for (int i = 0; i < 15; i++) begin
      fmt_v[i] = fmt_r[i];
    end
    fmt_v[15] = in_data_byte;
  end

  assign f_format = {fmt_v[1], fmt_v[0]};
  assign f_nch    = {fmt_v[3], fmt_v[2]};
  assign f_rate   = {fmt_v[7], fmt_v[6], fmt_v[5], fmt_v[4]};
  assign f_bps    = {fmt_v[11], fmt_v[10], fmt_v[9], fmt_v[8]};
  assign f_block  = {fmt_v[13], fmt_v[12]};
  assign f_bits   = {fmt_v[15], fmt_v[14]};
  assign prod     = f_nch[3:0] * f_rate[23:0];
  assign nch_bad  = (f_nch == 16'd0) || (f_nch > 16'(MAX_CHANNELS));
  assign rate_bad = (f_rate[23:0] == 24'd0) || (f_rate[31:24] != 8'd0);
  assign block_ok = {1'b0, f_block} == {f_nch, 1'b0};
  assign bps_ok   = f_bps == {3'b000, prod, 1'b0};
  assign fmt_ok   = (f_format == FMT_PCM) && !rate_bad && (f_bits == PCM_BITS) && !nch_bad &&
                    block_ok && bps_ok;
  assign fmt_idx  = 4'd0 - c_rem[3:0];

  // error decode
  always_comb begin
    err_v    = 1'b0;
    err_code = ST_SAMPLE;
    if (in_acc && short_err) begin
      err_v    = 1'b1;
      err_code = ST_NOT_WAVE;
    end else if (proc) begin
      unique case (c_phase)
        PH_HEAD: begin
          if (c_pos == 32'd3 && ws_n != TAG_RIFF) begin
            err_v    = 1'b1;
            err_code = ST_NOT_WAVE;
          end else if (c_pos == 32'd11) begin
            if (ws_n != TAG_WAVE) begin
              err_v    = 1'b1;
              err_code = ST_NOT_WAVE;
            end else if (c_tag != 32'd0) begin
              err_v    = 1'b1;
              err_code = ST_SIZE_MISMATCH;
            end else if (!walk_ok) begin
              err_v    = 1'b1;
              err_code = ST_NO_DATA;
            end
          end
        end
        PH_CHDR: begin
          if (rem_d == 32'd0) begin
            err_v = 1'b1;
            if (overrun) begin
              err_code = ST_OVERRUN;
            end else if (c_tag == TAG_FMT) begin
              if (ws_n != FMT_CHUNK_SIZE) err_code = ST_BAD_FMT;
              else err_v = 1'b0;
            end else if (c_tag == TAG_DATA) begin
              if (c_ch == 4'd0) err_code = ST_NO_FMT;
              else if (ws_n[0]) err_code = ST_MISALIGNED;
              else if (ws_n == 32'd0) err_code = ST_EMPTY_DATA;
              else err_v = 1'b0;
            end else if (ws_n == 32'd0 && !walk_ok) begin
              err_code = ST_NO_DATA;
            end else begin
              err_v = 1'b0;
            end
          end
        end
        PH_FMT: begin
          if (rem_d == 32'd0) begin
            err_v = 1'b1;
            if (f_format != FMT_PCM) err_code = ST_BAD_SAMPLE;
            else if (rate_bad) err_code = ST_BAD_RATE;
            else if (f_bits != PCM_BITS) err_code = ST_BAD_SAMPLE;
            else if (nch_bad) err_code = ST_BAD_CHANNELS;
            else if (!block_ok || !bps_ok) err_code = ST_INCONSISTENT;
            else if (!walk_ok) err_code = ST_NO_DATA;
            else err_v = 1'b0;
          end
        end
        PH_SKIP: begin
          if (rem_d == 32'd0 && !walk_ok) begin
            err_v    = 1'b1;
            err_code = ST_NO_DATA;
          end
        end
        default: begin
          err_v = 1'b0;
        end
      endcase
    end
  end

  // next state
  always_comb begin
    phase_nxt = in_acc ? c_phase : phase_r;
    pos_nxt   = in_acc ? c_pos : pos_r;
    ws_nxt    = in_acc ? c_ws : ws_r;
    tag_nxt   = in_acc ? c_tag : tag_r;
    rem_nxt   = in_acc ? c_rem : rem_r;
    chans_nxt = in_acc ? c_ch : chans_r;
    rate_nxt  = in_acc ? c_rate : rate_r;
    low_nxt   = in_acc ? c_low : low_r;
    cnt_nxt   = in_acc ? c_cnt : cnt_r;
    if (proc) begin
      pos_nxt = next_pos;
      ws_nxt  = ws_n;
      unique case (c_phase)
        PH_HEAD: begin
          if (c_pos == 32'd7) tag_nxt = {31'd0, hdr_sz_bad};
          if (c_pos == 32'd11) begin
            phase_nxt = PH_CHDR;
            rem_nxt   = CHDR_BYTES;
          end
        end
        PH_CHDR: begin
          rem_nxt = rem_d;
          if (rem_d == 32'd4) tag_nxt = ws_n;
          if (rem_d == 32'd0) begin
            rem_nxt = ws_n;
            if (c_tag == TAG_FMT) begin
              phase_nxt = PH_FMT;
            end else if (c_tag == TAG_DATA) begin
              phase_nxt = PH_DATA;
              cnt_nxt   = 3'd0;
            end else if (ws_n == 32'd0) begin
              phase_nxt = PH_CHDR;
              rem_nxt   = CHDR_BYTES;
            end else begin
              phase_nxt = PH_SKIP;
            end
          end
        end
        PH_FMT: begin
          rem_nxt = rem_d;
          if (rem_d == 32'd0 && fmt_ok) begin
            chans_nxt = f_nch[3:0];
            rate_nxt  = f_rate[23:0];
            phase_nxt = PH_CHDR;
            rem_nxt   = CHDR_BYTES;
          end
        end
        PH_SKIP: begin
          rem_nxt = rem_d;
          if (rem_d == 32'd0) begin
            phase_nxt = PH_CHDR;
            rem_nxt   = CHDR_BYTES;
          end
        end
        PH_DATA: begin
          rem_nxt = rem_d;
          if (!c_rem[0]) begin
            low_nxt = in_data_byte;
          end else begin
            cnt_nxt = (({1'b0, c_cnt} + 4'd1) >= c_ch) ? 3'd0 : c_cnt + 3'd1;
            if (rem_d == 32'd0) phase_nxt = PH_DONE;
          end
        end
        default: begin
          phase_nxt = PH_DONE;
        end
      endcase
    end
    if (err_v) phase_nxt = PH_DONE;
  end

  // result word
  always_comb begin
    res_v      = err_v || (proc && c_phase == PH_DATA && c_rem[0]);
    res_sample = err_v ? 16'd0 : {in_data_byte, c_low};
    res_ch     = err_v ? 3'd0 : c_cnt;
    res_status = err_v ? err_code : ST_SAMPLE;
    res_last   = err_v || (rem_d == 32'd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r   <= '0;
      phase_r <= PH_IDLE;
      pos_r   <= '0;
      ws_r    <= '0;
      tag_r   <= '0;
      rem_r   <= '0;
      chans_r <= '0;
      rate_r  <= '0;
      low_r   <= '0;
      cnt_r   <= '0;
    end else begin
      if (cfg_wr_en) len_r <= cfg_wr_data;
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      ws_r    <= ws_nxt;
      tag_r   <= tag_nxt;
      rem_r   <= rem_nxt;
      chans_r <= chans_nxt;
      rate_r  <= rate_nxt;
      low_r   <= low_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (proc && c_phase == PH_FMT) fmt_r[fmt_idx] <= in_data_byte;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_v) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_v) begin
      out_sample_r <= res_sample;
      out_ch_r     <= res_ch;
      out_count_r  <= chans_nxt;
      out_rate_r   <= rate_nxt;
      out_status_r <= res_status;
      out_last_r   <= res_last;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_sample        = $signed(out_sample_r);
  assign out_channel_index = out_ch_r;
  assign out_channel_count = out_count_r;
  assign out_sample_rate   = out_rate_r;
  assign out_status        = out_status_r;
  assign out_last          = out_last_r;

endmodule
